// ===== sv/hztt_pkg.sv =====
package hztt_pkg;

  localparam int COORD_W = 20;
  localparam int RAD_W   = 12;
  localparam int CFG_W   = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int SUM_W   = SQ_W + 2;

  localparam logic [1:0] KIND_MARK    = 2'd0;
  localparam logic [1:0] KIND_POINT   = 2'd1;
  localparam logic [1:0] KIND_TICK    = 2'd2;
  localparam logic [1:0] KIND_NEAREST = 2'd3;

  // operand select for the shared square unit
  typedef struct packed {
    logic              go;
    logic signed [COORD_W-1:0] a;
    logic signed [COORD_W-1:0] b;
  } sq_req_t;

endpackage

// ===== sv/hztt_sq_unit.sv =====
module hztt_sq_unit
  import hztt_pkg::*;
(
  input  logic                clk,
  input  hztt_pkg::sq_req_t   req,
  output logic [SQ_W-1:0]     sq
);

  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        mag;

  always_comb begin
    diff = DIFF_W'(req.a) - DIFF_W'(req.b);
    mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  end

  // registered square, one per cycle while req.go is high
  always_ff @(posedge clk) begin
    if (req.go) begin
      sq <= mag * mag;
    end
  end

endmodule

// ===== sv/hazard_zone_table_with_ttl_core.sv =====
// per stored zone: S_RD, S_SQX, S_SQY, S_SQZ, S_EVAL for a point query, the same
// without S_SQZ for mark and nearest, S_RD and S_EVAL for tick, plus setup and result
// throughput: one transaction at a time; in_stall is high while a walk runs
// the single registered square unit sets the per-zone step count
// reset: synchronous rst clears zone count, replace pointer, control and
// refresh_dist_sq (1024); zone storage is not cleared
module hazard_zone_table_with_ttl_core
  import hztt_pkg::*;
#(
  parameter int MAX_ZONES  = 16,
  parameter int LIFE_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_W-1:0]          cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                kind,
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic signed [COORD_W-1:0] pos_z,
  input  logic [RAD_W-1:0]          zone_radius,
  input  logic [15:0]               lifetime,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      inside_res,
  output logic                      found,
  output logic signed [COORD_W-1:0] near_x,
  output logic signed [COORD_W-1:0] near_y,
  output logic signed [COORD_W-1:0] near_z,
  output logic [RAD_W-1:0]          near_radius
);

  localparam int IDX_W = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam int CNT_W = $clog2(MAX_ZONES + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;  // register table entry
  localparam logic [2:0] S_SQX  = 3'd2;  // square of dx
  localparam logic [2:0] S_SQY  = 3'd3;  // square of dy
  localparam logic [2:0] S_SQZ  = 3'd4;  // square of dz
  localparam logic [2:0] S_EVAL = 3'd5;  // compare and act
  localparam logic [2:0] S_OUT  = 3'd6;  // result waits for taker

  // zone storage
  logic signed [COORD_W-1:0] mem_cx [MAX_ZONES];
  logic signed [COORD_W-1:0] mem_cy [MAX_ZONES];
  logic signed [COORD_W-1:0] mem_cz [MAX_ZONES];
  logic [RAD_W-1:0]          mem_rad [MAX_ZONES];
  logic [LIFE_WIDTH-1:0]     mem_life [MAX_ZONES];

  logic [CFG_W-1:0]  refresh_dist_sq;
  logic [2:0]        state;
  logic [CNT_W-1:0]  zone_count;
  logic [IDX_W-1:0]  replace_ptr;
  logic [CNT_W-1:0]  idx;

  // captured transaction
  logic [1:0]                op;
  logic signed [COORD_W-1:0] qx, qy, qz;
  logic [RAD_W-1:0]          qrad;
  logic [LIFE_WIDTH-1:0]     qlife;

  // entry being examined
  logic signed [COORD_W-1:0] ex, ey, ez;
  logic [RAD_W-1:0]          erad;
  logic [LIFE_WIDTH-1:0]     elife;
  logic [SUM_W-1:0]          dsum;
  logic [2*RAD_W-1:0]        r2;

  // nearest tracking
  logic                      best_ok;
  logic [SUM_W-1:0]          best;

  sq_req_t          sreq;
  logic [SQ_W-1:0]  sq;

  hztt_sq_unit u_sq (
    .clk (clk),
    .req (sreq),
    .sq  (sq)
  );

  // lifetime saturates when LIFE_WIDTH is narrower than the port
  function automatic logic [LIFE_WIDTH-1:0] sat_life(input logic [15:0] v);
    logic [LIFE_WIDTH-1:0] m;
    m = '1;
    if (LIFE_WIDTH >= 16) return LIFE_WIDTH'(v);
    if ({16'd0, v} > 32'(m)) return m;
    return LIFE_WIDTH'(v);
  endfunction

  logic [IDX_W-1:0] ridx;
  logic [IDX_W-1:0] last_idx;
  logic             walk_done;
  logic             hit;
  logic [SUM_W-1:0] dsum_fin;

  always_comb begin
    ridx      = idx[IDX_W-1:0];
    last_idx  = IDX_W'(zone_count - CNT_W'(1));
    walk_done = (idx >= zone_count);
    sreq.go = 1'b1;
    sreq.a  = ex;
    sreq.b  = qx;
    unique case (state)
      S_SQY:   begin sreq.a = ey; sreq.b = qy; end
      S_SQZ:   begin sreq.a = ez; sreq.b = qz; end
      default: begin sreq.a = ex; sreq.b = qx; end
    endcase
    // squares are registered and arrive in the cycle after their operand select
    dsum_fin = dsum;
    if (state == S_EVAL && op == KIND_POINT) dsum_fin = dsum + SUM_W'(sq);
    hit = dsum_fin < SUM_W'(r2);
  end

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      zone_count      <= '0;
      replace_ptr     <= '0;
      refresh_dist_sq <= CFG_W'(1024);
    end else begin
      if (cfg_we) refresh_dist_sq <= cfg_wdata;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op      <= kind;
            qx      <= pos_x;
            qy      <= pos_y;
            qz      <= pos_z;
            qrad    <= zone_radius;
            qlife   <= sat_life(lifetime);
            idx     <= '0;
            best_ok <= 1'b0;
            best    <= '0;
            inside_res  <= 1'b0;
            found       <= 1'b0;
            near_x      <= '0;
            near_y      <= '0;
            near_z      <= '0;
            near_radius <= '0;
            state   <= S_RD;
          end
        end
        S_RD: begin
          if (walk_done) begin
            if (op == KIND_MARK) begin
              // no zone close enough: append or overwrite
              if (zone_count < CNT_W'(MAX_ZONES)) begin
                mem_cx[IDX_W'(zone_count)]   <= qx;
                mem_cy[IDX_W'(zone_count)]   <= qy;
                mem_cz[IDX_W'(zone_count)]   <= qz;
                mem_rad[IDX_W'(zone_count)]  <= qrad;
                mem_life[IDX_W'(zone_count)] <= qlife;
                zone_count <= zone_count + CNT_W'(1);
              end else begin
                mem_cx[replace_ptr]   <= qx;
                mem_cy[replace_ptr]   <= qy;
                mem_cz[replace_ptr]   <= qz;
                mem_rad[replace_ptr]  <= qrad;
                mem_life[replace_ptr] <= qlife;
                replace_ptr <= (replace_ptr == IDX_W'(MAX_ZONES - 1)) ? '0
                               : replace_ptr + IDX_W'(1);
              end
              state <= S_IDLE;
            end else if (op == KIND_TICK) begin
              state <= S_IDLE;
            end else begin
              state <= S_OUT;
            end
          end else begin
            ex    <= mem_cx[ridx];
            ey    <= mem_cy[ridx];
            ez    <= mem_cz[ridx];
            erad  <= mem_rad[ridx];
            elife <= mem_life[ridx];
            state <= (op == KIND_TICK) ? S_EVAL : S_SQX;
          end
        end
        S_SQX: begin
          r2    <= erad * erad;
          state <= S_SQY;
        end
        S_SQY: begin
          dsum  <= SUM_W'(sq);
          state <= (op == KIND_POINT) ? S_SQZ : S_EVAL;
        end
        S_SQZ: begin
          dsum  <= dsum + SUM_W'(sq);
          state <= S_EVAL;
        end
        S_EVAL: begin
          state <= S_RD;
          unique case (op)
            KIND_MARK: begin
              if (dsum + SUM_W'(sq) < SUM_W'(refresh_dist_sq)) begin
                mem_life[ridx] <= qlife;
                state <= S_IDLE;
              end else begin
                idx <= idx + CNT_W'(1);
              end
            end
            KIND_TICK: begin
              if (elife <= LIFE_WIDTH'(1)) begin
                // expired: last entry moves in and is examined next
                mem_cx[ridx]   <= mem_cx[last_idx];
                mem_cy[ridx]   <= mem_cy[last_idx];
                mem_cz[ridx]   <= mem_cz[last_idx];
                mem_rad[ridx]  <= mem_rad[last_idx];
                mem_life[ridx] <= mem_life[last_idx];
                zone_count     <= zone_count - CNT_W'(1);
              end else begin
                mem_life[ridx] <= elife - LIFE_WIDTH'(1);
                idx <= idx + CNT_W'(1);
              end
            end
            KIND_POINT: begin
              if (hit) begin
                inside_res <= 1'b1;
                state      <= S_OUT;
              end else begin
                idx <= idx + CNT_W'(1);
              end
            end
            default: begin
              // nearest: the z square was never started, add dy now
              if ((dsum + SUM_W'(sq)) < SUM_W'(r2) &&
                  (!best_ok || (dsum + SUM_W'(sq)) < best)) begin
                best_ok     <= 1'b1;
                best        <= dsum + SUM_W'(sq);
                found       <= 1'b1;
                near_x      <= ex;
                near_y      <= ey;
                near_z      <= ez;
                near_radius <= erad;
              end
              idx <= idx + CNT_W'(1);
            end
          endcase
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/hztt_checker.sv =====
module hztt_checker
  import hztt_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic inside_res,
  input logic found,
  input logic [RAD_W-1:0] near_radius
);

  // a result is offered only while the block holds off new transactions
  a_out_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("result without busy");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");

  // a result never reports both query kinds
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(inside_res && found)) else $error("mixed result");

  // a containing zone has nonzero radius
  a_rad: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> near_radius != '0) else $error("zero radius hit");

  // accepted transaction makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("not busy");

endmodule

bind hazard_zone_table_with_ttl_core hztt_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .inside_res  (inside_res),
  .found       (found),
  .near_radius (near_radius)
);
